// ===== hdl/sdsm_pkg.sv =====
// Shared widths, reset values and codes for the separation distance stop monitor.
// No dependencies; compile this file first.
`timescale 1ns / 1ps

package sdsm_pkg;

  // Field widths
  localparam int POSITION_WIDTH = 16;
  localparam int VAR_W          = 24;
  localparam int DIST_W         = 17;
  localparam int CONF_W         = 8;

  // Configuration port
  localparam int CFG_DATA_W = (DIST_W > CONF_W) ? DIST_W : CONF_W;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SEP    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CONFIDENCE = CFG_IDX_W'(1);

  // Reset values: threshold at full scale so the monitor stops until configured
  localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
  localparam logic [CONF_W-1:0] CONF_RESET = CONF_W'(8);

  // Transition codes on the result channel
  localparam logic [1:0] TRANS_NONE   = 2'd0;
  localparam logic [1:0] TRANS_STOP   = 2'd1;
  localparam logic [1:0] TRANS_RESUME = 2'd2;

endpackage

// ===== hdl/sdsm_if.sv =====
// Valid/ready channel interfaces for pose input and monitor result transactions.
// Depends on sdsm_pkg for field widths.
`timescale 1ns / 1ps

interface sdsm_in_if;
  import sdsm_pkg::*;

  logic                             valid;
  logic                             ready;
  logic signed [POSITION_WIDTH-1:0] robot_x;
  logic signed [POSITION_WIDTH-1:0] robot_y;
  logic signed [POSITION_WIDTH-1:0] robot_z;
  logic        [VAR_W-1:0]          robot_var_x;
  logic        [VAR_W-1:0]          robot_var_y;
  logic        [VAR_W-1:0]          robot_var_z;
  logic signed [POSITION_WIDTH-1:0] operator_x;
  logic signed [POSITION_WIDTH-1:0] operator_y;
  logic signed [POSITION_WIDTH-1:0] operator_z;
  logic        [VAR_W-1:0]          operator_var_x;
  logic        [VAR_W-1:0]          operator_var_y;
  logic        [VAR_W-1:0]          operator_var_z;

  modport source (
    output valid, robot_x, robot_y, robot_z, robot_var_x, robot_var_y, robot_var_z,
           operator_x, operator_y, operator_z, operator_var_x, operator_var_y,
           operator_var_z,
    input  ready
  );

  modport sink (
    input  valid, robot_x, robot_y, robot_z, robot_var_x, robot_var_y, robot_var_z,
           operator_x, operator_y, operator_z, operator_var_x, operator_var_y,
           operator_var_z,
    output ready
  );
endinterface

interface sdsm_out_if;
  import sdsm_pkg::*;

  logic              valid;
  logic              ready;
  logic              stop_active;
  logic [1:0]        transition;
  logic [DIST_W-1:0] worst_distance_mm;

  modport source (
    output valid, stop_active, transition, worst_distance_mm,
    input  ready
  );

  modport sink (
    input  valid, stop_active, transition, worst_distance_mm,
    output ready
  );
endinterface

// ===== hdl/separation_distance_stop_monitor_core.sv =====
// Separation distance stop monitor: top level with sequencer and shared datapath.
// Depends on sdsm_pkg and the channel interfaces in sdsm_if.sv.
`timescale 1ns / 1ps

// Each pose transaction runs, between acceptance and the next possible
// acceptance, multiply/accumulate steps on the shared multiplier, two
// 24-step divisions and three 17-step square roots on the shared subtractor,
// one scale multiply and a load of the result. The input is ready only
// while the sequencer is idle; the result sits in an output register, so a new
// pose is taken while the previous result still waits, and the sequencer holds
// its final step until that register is free. The stop threshold resets to full
// scale, so every pose requests stop until software lowers it. Write the
// configuration registers only while the monitor is idle.
module separation_distance_stop_monitor_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  sdsm_in_if.sink                               item_i,
  sdsm_out_if.source                            result_o,
  input  logic                                  cfg_we_i,
  input  logic [sdsm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [sdsm_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import sdsm_pkg::*;

  // Datapath widths
  localparam int PW     = POSITION_WIDTH;
  localparam int SQ_W   = 2 * PW;                 // one squared coordinate
  localparam int DEN_W  = 2 * PW;                 // sum of squared coordinates
  localparam int NUM_W  = 2 * PW + VAR_W;         // variance-weighted sum
  localparam int QUO_W  = VAR_W;                  // weighted mean variance
  localparam int SIG_W  = VAR_W / 2;              // radial deviation
  localparam int DSQ_W  = 2 * PW + 2;             // squared distance
  localparam int D_W    = PW + 1;                 // distance
  localparam int SRC_W  = DSQ_W;                  // root operand shifter
  localparam int MA_W   = SQ_W;
  localparam int MB_W   = (VAR_W > PW) ? VAR_W : PW;
  localparam int PROD_W = MA_W + MB_W;
  localparam int REM_W  = (DEN_W > D_W + 2) ? DEN_W : D_W + 2;
  localparam int SUB_W  = REM_W + 1;
  localparam int SC_W   = SIG_W + 1 + CONF_W;     // k times deviation sum
  localparam int QW     = ((D_W + 2 > SC_W) ? D_W + 2 : SC_W) + 1;
  localparam int IT_MAX = (QUO_W > SRC_W / 2) ? QUO_W : SRC_W / 2;
  localparam int IT_W   = $clog2(IT_MAX);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_ROOT  = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // Product groups during multiply/accumulate
  localparam logic [1:0] GRP_ROBOT = 2'd0;
  localparam logic [1:0] GRP_OPER  = 2'd1;
  localparam logic [1:0] GRP_DIFF  = 2'd2;

  // Divide / root jobs
  localparam logic [1:0] JOB_ROBOT = 2'd0;
  localparam logic [1:0] JOB_OPER  = 2'd1;
  localparam logic [1:0] JOB_DIST  = 2'd2;

  localparam logic [1:0] AXIS_LAST = 2'd2;

  // Control registers
  logic [2:0]        state_q, state_d;
  logic [1:0]        grp_q, grp_d;
  logic [1:0]        axis_q, axis_d;
  logic              kind_q, kind_d;
  logic              ph_q, ph_d;
  logic [1:0]        jb_q, jb_d;
  logic [IT_W-1:0]   it_q, it_d;
  logic              stop_q, stop_d;
  logic [DIST_W-1:0] min_sep_q, min_sep_d;
  logic [CONF_W-1:0] conf_q, conf_d;
  logic              out_valid_q, out_valid_d;

  // Payload registers
  logic signed [PW-1:0] pos_r_q [3];
  logic signed [PW-1:0] pos_r_d [3];
  logic signed [PW-1:0] pos_o_q [3];
  logic signed [PW-1:0] pos_o_d [3];
  logic [VAR_W-1:0]     var_r_q [3];
  logic [VAR_W-1:0]     var_r_d [3];
  logic [VAR_W-1:0]     var_o_q [3];
  logic [VAR_W-1:0]     var_o_d [3];
  logic [DEN_W-1:0]     den_r_q, den_r_d, den_o_q, den_o_d;
  logic [NUM_W-1:0]     num_r_q, num_r_d, num_o_q, num_o_d;
  logic [DSQ_W-1:0]     dsq_q, dsq_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [SRC_W-1:0]     src_q, src_d;
  logic [D_W-1:0]       root_q, root_d;
  logic [SIG_W-1:0]     sig_r_q, sig_r_d, sig_o_q, sig_o_d;
  logic [D_W-1:0]       dist_q, dist_d;
  logic                 out_stop_q, out_stop_d;
  logic [1:0]           out_trans_q, out_trans_d;
  logic [DIST_W-1:0]    out_worst_q, out_worst_d;

  // Shared datapath signals
  logic signed [PW-1:0] sel_r, sel_o;
  logic [PW:0]          abs_in, abs_neg;
  logic [PW-1:0]        mag;
  logic [VAR_W-1:0]     sel_var;
  logic [MA_W-1:0]      mul_a;
  logic [MB_W-1:0]      mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic [NUM_W-1:0]     acc_sel, acc_sum;
  logic [DEN_W-1:0]     den_sel;
  logic [SUB_W-1:0]     sub_a, sub_b;
  logic [SUB_W:0]       sub_diff;
  logic                 ge;
  logic [REM_W-1:0]     rem_next;
  logic [D_W-1:0]       root_new;
  logic [SIG_W:0]       sig_sum;
  logic [QW-1:0]        q_val;
  logic [QW-4:0]        q_shift;
  logic [DIST_W-1:0]    worst;
  logic                 below;
  logic                 in_fire, out_fire, done_go;

  assign in_fire  = item_i.valid && item_i.ready;
  assign out_fire = out_valid_q && result_o.ready;
  assign done_go  = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);

  // Pick the coordinate or coordinate difference for this step and take its magnitude
  assign sel_r   = pos_r_q[axis_q];
  assign sel_o   = pos_o_q[axis_q];
  assign abs_in  = (grp_q == GRP_DIFF) ? ({sel_r[PW-1], sel_r} - {sel_o[PW-1], sel_o}) :
                   (grp_q[0] ? {sel_o[PW-1], sel_o} : {sel_r[PW-1], sel_r});
  assign abs_neg = (~abs_in) + (PW + 1)'(1);
  assign mag     = abs_in[PW] ? abs_neg[PW-1:0] : abs_in[PW-1:0];
  assign sel_var = grp_q[0] ? var_o_q[axis_q] : var_r_q[axis_q];

  // Shared multiplier operands
  assign sig_sum = {1'b0, sig_r_q} + {1'b0, sig_o_q};
  always_comb begin
    if (state_q == ST_SCALE) begin
      mul_a = MA_W'(sig_sum);
      mul_b = MB_W'(conf_q);
    end else if (grp_q != GRP_DIFF && kind_q) begin
      mul_a = prod_q[SQ_W-1:0];
      mul_b = MB_W'(sel_var);
    end else begin
      mul_a = MA_W'(mag);
      mul_b = MB_W'(mag);
    end
  end
  assign mul_p = mul_a * mul_b;

  // Shared accumulator adder
  always_comb begin
    case (grp_q)
      GRP_ROBOT: acc_sel = kind_q ? num_r_q : NUM_W'(den_r_q);
      GRP_OPER:  acc_sel = kind_q ? num_o_q : NUM_W'(den_o_q);
      default:   acc_sel = NUM_W'(dsq_q);
    endcase
  end
  assign acc_sum = acc_sel + prod_q[NUM_W-1:0];

  // Shared subtract/compare unit for restoring division and digit-by-digit root
  assign den_sel = jb_q[0] ? den_o_q : den_r_q;
  always_comb begin
    if (state_q == ST_DIV) begin
      sub_a = SUB_W'({rem_q[DEN_W-1:0], src_q[QUO_W-1]});
      sub_b = SUB_W'(den_sel);
    end else begin
      sub_a = SUB_W'({rem_q[REM_W-2:0], src_q[SRC_W-1:SRC_W-2]});
      sub_b = SUB_W'({root_q, 2'b01});
    end
  end
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge       = ~sub_diff[SUB_W];
  assign rem_next = ge ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
  assign root_new = {root_q[D_W-2:0], ge};

  // Worst-case distance in millimetres, computed in quarter millimetres, floored and saturated
  assign q_val   = QW'({dist_q, 2'b00}) - QW'(prod_q[SC_W-1:0]);
  assign q_shift = q_val[QW-2:2];
  assign worst   = q_val[QW-1] ? '0 :
                   ((q_shift > (QW - 3)'(DIST_MAX)) ? DIST_MAX : q_shift[DIST_W-1:0]);
  assign below   = (worst <= min_sep_q);

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    grp_d       = grp_q;
    axis_d      = axis_q;
    kind_d      = kind_q;
    ph_d        = ph_q;
    jb_d        = jb_q;
    it_d        = it_q;
    stop_d      = stop_q;
    min_sep_d   = min_sep_q;
    conf_d      = conf_q;
    pos_r_d     = pos_r_q;
    pos_o_d     = pos_o_q;
    var_r_d     = var_r_q;
    var_o_d     = var_o_q;
    den_r_d     = den_r_q;
    den_o_d     = den_o_q;
    num_r_d     = num_r_q;
    num_o_d     = num_o_q;
    dsq_d       = dsq_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    src_d       = src_q;
    root_d      = root_q;
    sig_r_d     = sig_r_q;
    sig_o_d     = sig_o_q;
    dist_d      = dist_q;
    out_stop_d  = out_stop_q;
    out_trans_d = out_trans_q;
    out_worst_d = out_worst_q;
    out_valid_d = out_fire ? 1'b0 : out_valid_q;

    // Configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_SEP:    min_sep_d = cfg_data_i[DIST_W-1:0];
        REG_CONFIDENCE: conf_d    = cfg_data_i[CONF_W-1:0];
        default:        ;
      endcase
    end

    case (state_q)
      // Capture the pose transaction and clear the accumulators
      ST_IDLE: begin
        if (in_fire) begin
          pos_r_d[0] = item_i.robot_x;
          pos_r_d[1] = item_i.robot_y;
          pos_r_d[2] = item_i.robot_z;
          pos_o_d[0] = item_i.operator_x;
          pos_o_d[1] = item_i.operator_y;
          pos_o_d[2] = item_i.operator_z;
          var_r_d[0] = item_i.robot_var_x;
          var_r_d[1] = item_i.robot_var_y;
          var_r_d[2] = item_i.robot_var_z;
          var_o_d[0] = item_i.operator_var_x;
          var_o_d[1] = item_i.operator_var_y;
          var_o_d[2] = item_i.operator_var_z;
          den_r_d    = '0;
          den_o_d    = '0;
          num_r_d    = '0;
          num_o_d    = '0;
          dsq_d      = '0;
          grp_d      = GRP_ROBOT;
          axis_d     = '0;
          kind_d     = 1'b0;
          ph_d       = 1'b0;
          state_d    = ST_MUL;
        end
      end

      // Multiply on phase 0, accumulate on phase 1, then advance the step
      ST_MUL: begin
        if (!ph_q) begin
          prod_d = mul_p;
          ph_d   = 1'b1;
        end else begin
          ph_d = 1'b0;
          case (grp_q)
            GRP_ROBOT: begin
              if (kind_q) num_r_d = acc_sum;
              else        den_r_d = acc_sum[DEN_W-1:0];
            end
            GRP_OPER: begin
              if (kind_q) num_o_d = acc_sum;
              else        den_o_d = acc_sum[DEN_W-1:0];
            end
            default: dsq_d = acc_sum[DSQ_W-1:0];
          endcase
          if (grp_q != GRP_DIFF && !kind_q) begin
            kind_d = 1'b1;
          end else begin
            kind_d = 1'b0;
            if (axis_q == AXIS_LAST) begin
              axis_d = '0;
              if (grp_q == GRP_DIFF) begin
                // Start the robot division
                jb_d    = JOB_ROBOT;
                rem_d   = REM_W'(num_r_q[NUM_W-1:QUO_W]);
                src_d   = SRC_W'(num_r_q[QUO_W-1:0]);
                it_d    = IT_W'(QUO_W - 1);
                state_d = ST_DIV;
              end else begin
                grp_d = grp_q + 2'd1;
              end
            end else begin
              axis_d = axis_q + 2'd1;
            end
          end
        end
      end

      // One quotient bit per cycle; the quotient shifts into the low source bits
      ST_DIV: begin
        rem_d = rem_next;
        src_d = {src_q[SRC_W-1:QUO_W], src_q[QUO_W-2:0], ge};
        if (it_q == '0) begin
          rem_d   = '0;
          root_d  = '0;
          it_d    = IT_W'(SRC_W / 2 - 1);
          state_d = ST_ROOT;
        end else begin
          it_d = it_q - IT_W'(1);
        end
      end

      // One root bit per cycle, two operand bits consumed
      ST_ROOT: begin
        rem_d  = rem_next;
        src_d  = {src_q[SRC_W-3:0], 2'b00};
        root_d = root_new;
        if (it_q == '0) begin
          case (jb_q)
            JOB_ROBOT: begin
              sig_r_d = (den_r_q == '0) ? '0 : root_new[SIG_W-1:0];
              jb_d    = JOB_OPER;
              rem_d   = REM_W'(num_o_q[NUM_W-1:QUO_W]);
              src_d   = SRC_W'(num_o_q[QUO_W-1:0]);
              it_d    = IT_W'(QUO_W - 1);
              state_d = ST_DIV;
            end
            JOB_OPER: begin
              sig_o_d = (den_o_q == '0) ? '0 : root_new[SIG_W-1:0];
              jb_d    = JOB_DIST;
              rem_d   = '0;
              root_d  = '0;
              src_d   = dsq_q;
              it_d    = IT_W'(SRC_W / 2 - 1);
            end
            default: begin
              dist_d  = root_new;
              state_d = ST_SCALE;
            end
          endcase
        end else begin
          it_d = it_q - IT_W'(1);
        end
      end

      // k times the deviation sum on the shared multiplier
      ST_SCALE: begin
        prod_d  = mul_p;
        state_d = ST_DONE;
      end

      // Update the latch and load the result once the output register is free
      ST_DONE: begin
        if (done_go) begin
          out_valid_d = 1'b1;
          out_worst_d = worst;
          out_trans_d = TRANS_NONE;
          if (!stop_q && below) begin
            stop_d      = 1'b1;
            out_trans_d = TRANS_STOP;
          end else if (stop_q && !below) begin
            stop_d      = 1'b0;
            out_trans_d = TRANS_RESUME;
          end
          out_stop_d = stop_d;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grp_q       <= GRP_ROBOT;
      axis_q      <= '0;
      kind_q      <= 1'b0;
      ph_q        <= 1'b0;
      jb_q        <= JOB_ROBOT;
      it_q        <= '0;
      stop_q      <= 1'b0;
      min_sep_q   <= DIST_MAX;
      conf_q      <= CONF_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      grp_q       <= grp_d;
      axis_q      <= axis_d;
      kind_q      <= kind_d;
      ph_q        <= ph_d;
      jb_q        <= jb_d;
      it_q        <= it_d;
      stop_q      <= stop_d;
      min_sep_q   <= min_sep_d;
      conf_q      <= conf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload state
  always_ff @(posedge clk_i) begin
    pos_r_q     <= pos_r_d;
    pos_o_q     <= pos_o_d;
    var_r_q     <= var_r_d;
    var_o_q     <= var_o_d;
    den_r_q     <= den_r_d;
    den_o_q     <= den_o_d;
    num_r_q     <= num_r_d;
    num_o_q     <= num_o_d;
    dsq_q       <= dsq_d;
    prod_q      <= prod_d;
    rem_q       <= rem_d;
    src_q       <= src_d;
    root_q      <= root_d;
    sig_r_q     <= sig_r_d;
    sig_o_q     <= sig_o_d;
    dist_q      <= dist_d;
    out_stop_q  <= out_stop_d;
    out_trans_q <= out_trans_d;
    out_worst_q <= out_worst_d;
  end

  // Channel outputs
  assign item_i.ready               = (state_q == ST_IDLE);
  assign result_o.valid             = out_valid_q;
  assign result_o.stop_active       = out_stop_q;
  assign result_o.transition        = out_trans_q;
  assign result_o.worst_distance_mm = out_worst_q;

`ifndef SYNTHESIS
  // An accepted pose starts the multiply sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_MUL)
    else $error("accepted pose did not start the sequence");

  // Division remainder stays below a nonzero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && den_sel != '0) |-> rem_q < REM_W'(den_sel))
    else $error("division remainder out of range");

  // Root remainder never exceeds twice the partial root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROOT |-> rem_q <= REM_W'({root_q, 1'b0}))
    else $error("root remainder out of range");

  // Every latch change is reported on a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q != $past(stop_q) |-> (out_valid_q && out_trans_q != TRANS_NONE))
    else $error("stop latch changed without a reported transition");
`endif

endmodule
